### rtl/dckv_pkg.sv
// Shared types, constants and the key-to-note ROM of the key velocity scanner.
`default_nettype none

package dckv_pkg;

  localparam int KEY_GROUPS  = 4;
  localparam int KEY_COLUMNS = 8;
  localparam int NOTE_COUNT  = 128;
  localparam int ROM_GROUPS  = 4;
  localparam int ROM_COLUMNS = 8;
  localparam int KEY_SLOTS   = KEY_GROUPS * KEY_COLUMNS;
  localparam int SLOT_W      = $clog2(KEY_SLOTS);

  localparam int GROUP_W  = 2;
  localparam int COLUMN_W = 3;
  localparam int TIME_W   = 32;
  localparam int NOTE_W   = 7;
  localparam int VEL_W    = 9;
  localparam int WINDOW_W = 16;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = WINDOW_W;

  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_VEL = 1'd1;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET  = 16'd120;
  localparam logic [VEL_W-1:0]    MIN_VEL_RESET = 9'd38;
  localparam logic [VEL_W-1:0]    FULL_VEL      = 9'd256;

  // Quotient bits of the velocity division; the quotient stays below 256.
  localparam int QUO_W = 8;
  localparam int DIV_CNT_W = $clog2(QUO_W);

  localparam logic EV_NOTE_ON  = 1'b0;
  localparam logic EV_NOTE_OFF = 1'b1;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_TRIG  = 2'd2;

  typedef struct packed {
    logic [GROUP_W-1:0]  key_group;
    logic [COLUMN_W-1:0] key_column;
    logic                second_contact;
    logic                pressed;
    logic [TIME_W-1:0]   now_ms;
  } in_word_t;

  typedef struct packed {
    logic              event_kind;
    logic [NOTE_W-1:0] note_number;
    logic [VEL_W-1:0]  velocity;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_EMIT,
    ACT_DIVIDE
  } act_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic [NOTE_W-1:0] note_of(input logic [GROUP_W-1:0] group,
                                                input logic [COLUMN_W-1:0] column);
    logic [NOTE_W-1:0] n;
    n = '0;
    case (group)
      2'd0: begin
        case (column)
          3'd0: n = 7'd68;
          3'd1: n = 7'd69;
          3'd2: n = 7'd70;
          3'd3: n = 7'd71;
          default: n = '0;
        endcase
      end
      2'd1: begin
        case (column)
          3'd0: n = 7'd60;
          3'd1: n = 7'd61;
          3'd2: n = 7'd62;
          3'd3: n = 7'd63;
          3'd4: n = 7'd64;
          3'd5: n = 7'd65;
          default: n = '0;
        endcase
      end
      2'd2: begin
        case (column)
          3'd0: n = 7'd52;
          3'd1: n = 7'd53;
          3'd2: n = 7'd54;
          3'd3: n = 7'd55;
          3'd4: n = 7'd56;
          3'd5: n = 7'd57;
          3'd6: n = 7'd58;
          default: n = '0;
        endcase
      end
      2'd3: begin
        case (column)
          3'd4: n = 7'd48;
          3'd5: n = 7'd51;
          default: n = '0;
        endcase
      end
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/dual_contact_key_velocity.sv
// Top level of the dual-contact key velocity scanner.
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid / in_stall  | group, column, contact, level, ms
//   out     | output    | out_valid / out_stall| kind, note, velocity
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A sample is accepted (with the read of the contact time store), then decided
// from its key phase and the sounding map; a note-on between 2 ms and the
// window then runs the bit-serial divider, and any result loads the output register.
// Reset clears key phases and the 128-bit sounding map; the contact time store
// needs no clearing. The output register holds while out_stall is high; a new
// sample is still taken while a result waits.
`default_nettype none

module dual_contact_key_velocity (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire dckv_pkg::in_word_t          in_word,
  output logic                             out_valid,
  input  wire                              out_stall,
  output dckv_pkg::out_word_t              out_word,
  input  wire                              cfg_we,
  input  wire [dckv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire [dckv_pkg::CFG_DATA_W-1:0]   cfg_data
);

  dckv_pkg::cmd_t    cmd;
  dckv_pkg::status_t status;

  dckv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  dckv_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

### rtl/dckv_ctrl.sv
// Sequencer of the key velocity scanner: accept, decide, divide, emit.
`default_nettype none

module dckv_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  input  wire dckv_pkg::status_t status,
  output logic            in_stall,
  output dckv_pkg::cmd_t  cmd
);

  dckv_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dckv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dckv_pkg::ST_IDLE: begin
        if (in_valid) state_next = dckv_pkg::ST_DECIDE;
      end
      dckv_pkg::ST_DECIDE: begin
        case (status.act)
          dckv_pkg::ACT_EMIT:   state_next = dckv_pkg::ST_EMIT;
          dckv_pkg::ACT_DIVIDE: state_next = dckv_pkg::ST_DIVIDE;
          default:              state_next = dckv_pkg::ST_IDLE;
        endcase
      end
      dckv_pkg::ST_DIVIDE: begin
        if (status.div_done) state_next = dckv_pkg::ST_EMIT;
      end
      dckv_pkg::ST_EMIT: begin
        if (status.out_free) state_next = dckv_pkg::ST_IDLE;
      end
      default: state_next = dckv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state != dckv_pkg::ST_IDLE);
    cmd.load     = (state == dckv_pkg::ST_IDLE) && in_valid;
    cmd.decide   = (state == dckv_pkg::ST_DECIDE);
    cmd.div_step = (state == dckv_pkg::ST_DIVIDE);
    cmd.emit     = (state == dckv_pkg::ST_EMIT) && status.out_free;
  end

endmodule

`default_nettype wire

### rtl/dckv_datapath.sv
// Key state, contact time store, velocity divider and output register.
`default_nettype none

module dckv_datapath (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire dckv_pkg::in_word_t              in_word,
  input  wire dckv_pkg::cmd_t                  cmd,
  output dckv_pkg::status_t                    status,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output dckv_pkg::out_word_t                  out_word,
  input  wire                                  cfg_we,
  input  wire [dckv_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire [dckv_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int SW = dckv_pkg::SLOT_W;
  localparam int WW = dckv_pkg::WINDOW_W;
  localparam int TW = dckv_pkg::TIME_W;
  localparam int VW = dckv_pkg::VEL_W;
  localparam int QW = dckv_pkg::QUO_W;

  // configuration
  logic [WW-1:0] win;
  logic [VW-1:0] min_vel;

  // latched sample
  dckv_pkg::in_word_t        smp;
  logic [dckv_pkg::NOTE_W-1:0] note;
  logic [SW-1:0]             slot;
  logic [TW-1:0]             fct_rd;

  // key state
  logic [1:0]                         key_phase [dckv_pkg::KEY_SLOTS];
  logic [dckv_pkg::NOTE_COUNT-1:0]    sounding;
  logic [TW-1:0]                      fct_mem [dckv_pkg::KEY_SLOTS];

  // result build-up and divider
  logic                       kind;
  logic [VW-1:0]              vel;
  logic [WW:0]                div_rem;
  logic [QW-1:0]              div_quo;
  logic [dckv_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [SW-1:0]  slot_next;
  logic [1:0]     phase;
  logic           snd;
  logic [TW-1:0]  dt;
  logic           dt_small;
  logic           dt_over;
  logic           set_first;
  logic           strike;
  logic           release_key;
  dckv_pkg::act_t act;
  logic [WW:0]    rem_shift;
  logic           rem_ge;
  logic [QW-1:0]  quo_next;
  logic [VW-1:0]  vel_floor;
  logic [VW-1:0]  vel_out;

  assign slot_next = SW'(32'(in_word.key_group) * dckv_pkg::KEY_COLUMNS
                         + 32'(in_word.key_column));

  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= dckv_pkg::WINDOW_RESET;
      min_vel <= dckv_pkg::MIN_VEL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dckv_pkg::CFG_WINDOW:  win     <= cfg_data;
        dckv_pkg::CFG_MIN_VEL: min_vel <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp  <= in_word;
      note <= dckv_pkg::note_of(in_word.key_group, in_word.key_column);
      slot <= slot_next;
    end
  end

  // contact time store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.decide && set_first) fct_mem[slot] <= smp.now_ms;
    if (cmd.load) fct_rd <= fct_mem[slot_next];
  end

  assign phase    = key_phase[slot];
  assign snd      = sounding[note];
  assign dt       = smp.now_ms - fct_rd;
  assign dt_small = (dt <= TW'(1));
  assign dt_over  = (dt >= TW'(win));

  always_comb begin
    set_first   = 1'b0;
    strike      = 1'b0;
    release_key = 1'b0;
    act         = dckv_pkg::ACT_NONE;
    if (note != '0) begin
      if (smp.pressed && !smp.second_contact) begin
        set_first = (phase == dckv_pkg::PH_IDLE);
      end else if (smp.pressed) begin
        if (phase == dckv_pkg::PH_FIRST && !snd) begin
          strike = 1'b1;
          act    = (dt_small || dt_over) ? dckv_pkg::ACT_EMIT : dckv_pkg::ACT_DIVIDE;
        end
      end else if (!smp.second_contact && phase != dckv_pkg::PH_IDLE) begin
        release_key = 1'b1;
        if (snd) act = dckv_pkg::ACT_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dckv_pkg::KEY_SLOTS; i++) key_phase[i] <= dckv_pkg::PH_IDLE;
      sounding <= '0;
    end else if (cmd.decide) begin
      if (set_first) key_phase[slot] <= dckv_pkg::PH_FIRST;
      if (strike) begin
        key_phase[slot] <= dckv_pkg::PH_TRIG;
        sounding[note]  <= 1'b1;
      end
      if (release_key) begin
        key_phase[slot] <= dckv_pkg::PH_IDLE;
        sounding[note]  <= 1'b0;
      end
    end
  end

  // restoring division: quotient of (window - dt) * 256 / window, one bit a cycle
  assign rem_shift = {div_rem[WW-1:0], 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, win});
  assign quo_next  = {div_quo[QW-2:0], rem_ge};

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      kind    <= strike ? dckv_pkg::EV_NOTE_ON : dckv_pkg::EV_NOTE_OFF;
      vel     <= (strike && dt_small) ? dckv_pkg::FULL_VEL : '0;
      div_rem <= {1'b0, win - dt[WW-1:0]};
      div_quo <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= rem_ge ? (rem_shift - {1'b0, win}) : rem_shift;
      div_quo <= quo_next;
      div_cnt <= div_cnt + 1'b1;
      vel     <= VW'(quo_next);
    end
  end

  // clamp note-on velocity from below; a floor above full counts as full
  assign vel_floor = (min_vel > dckv_pkg::FULL_VEL) ? dckv_pkg::FULL_VEL : min_vel;
  assign vel_out   = (kind == dckv_pkg::EV_NOTE_ON && vel < vel_floor) ? vel_floor : vel;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word.event_kind  <= kind;
      out_word.note_number <= note;
      out_word.velocity    <= vel_out;
    end
  end

  always_comb begin
    status.act      = act;
    status.div_done = (div_cnt == dckv_pkg::DIV_CNT_W'(QW - 1));
    status.out_free = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire
